// File: rtl/ir_burst_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// ir_burst_sequencer_unit_defines.svh
// Assertion macros for the checker file of the IR burst sequencer.
// ----------------------------------------------------------------------------
`ifndef IR_BURST_SEQUENCER_UNIT_DEFINES_SVH
`define IR_BURST_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define IRBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define IRBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/irbs_pkg.sv
// ----------------------------------------------------------------------------
// irbs_pkg
// Types and constants of the IR burst sequencer.
// ----------------------------------------------------------------------------
package irbs_pkg;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 7;
  localparam int ENTRY_W = 24;
  localparam int DELAY_W = 26;
  localparam int SEQ_W   = 8;
  localparam int IVL_W   = 16;
  localparam int REP_W   = 8;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [9:0] US_PER_MS = 10'd1000;

  // register word index (paddr[3:2])
  localparam logic [1:0] REG_SEQ_LEN  = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_MIN_REP  = 2'd2;

  localparam logic [IVL_W-1:0] IVL_RESET = 16'd108;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_TX    = 3'd1,
    OP_RPT   = 3'd2,
    OP_STOP  = 3'd3,
    OP_ALARM = 3'd4
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_READ = 6'b000100,
    ST_STEP = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;  // acc <= interval * 1000
    logic sub;   // acc <= acc - table word
  } acc_ctrl_t;

endpackage

// File: rtl/irbs_pause_acc.sv
// ----------------------------------------------------------------------------
// irbs_pause_acc
// Subtract unit for the inter-frame pause: loads the frame period in
// microseconds, then takes off one table word per beat of the sweep.
// ----------------------------------------------------------------------------
module irbs_pause_acc #(
  parameter int ACC_W = 30
) (
  input  logic                          clk_i,
  input  irbs_pkg::acc_ctrl_t           ctrl_i,
  input  logic [irbs_pkg::IVL_W-1:0]    interval_i,
  input  logic [irbs_pkg::ENTRY_W-1:0]  word_i,
  input  logic                          rep_nz_i,
  output logic [irbs_pkg::DELAY_W-1:0]  pause_o
);
  import irbs_pkg::*;

  logic [DELAY_W-1:0]      prod;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] adj;

  assign prod = DELAY_W'(interval_i) * DELAY_W'(US_PER_MS);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.load) begin
      acc_d = $signed({{(ACC_W-DELAY_W){1'b0}}, prod});
    end else if (ctrl_i.sub) begin
      acc_d = acc_q - $signed({{(ACC_W-ENTRY_W){1'b0}}, word_i});
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // one less while repeats remain, floor of one
  assign adj     = acc_q - $signed(ACC_W'(rep_nz_i));
  assign pause_o = (adj[ACC_W-1] || adj == '0) ? DELAY_W'(1) : adj[DELAY_W-1:0];

endmodule

// File: rtl/ir_burst_sequencer_unit.sv
// ----------------------------------------------------------------------------
// ir_burst_sequencer_unit
// Plays a table of mark/space durations as an IR burst, one entry per alarm.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry an opcode (load entry, transmit, repeat, stop, alarm)
//   and, for a load, a table index and duration. Every input beat yields one
//   output beat: carrier state, delay to the next alarm in us (0 = none),
//   busy and a done pulse. Registers are to be set over the APB port only
//   while idle; the block does not enforce this. Load, stop, unknown
//   opcodes and idle alarms are answered from the execute state; a playback
//   step passes execute, read and step (one table read). A frame end sweeps
//   len words (at most MAX_ENTRIES) via the single read port and accumulator.
//   One beat is worked on at a time; in_stall_o is high until the sequencer
//   is back in idle. A finished result sits in an output register, so the
//   next beat may be taken while the receiver stalls; its result then waits
//   until the register is free.
//   Reset clears playback state and loads register defaults; the duration
//   table is not cleared and must be written before it is played.
// ----------------------------------------------------------------------------
module ir_burst_sequencer_unit #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [irbs_pkg::APB_AW-1:0]    paddr,
  input  logic [irbs_pkg::APB_DW-1:0]    pwdata,
  output logic [irbs_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [irbs_pkg::OP_W-1:0]      opcode_i,
  input  logic [irbs_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [irbs_pkg::ENTRY_W-1:0]   entry_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           carrier_on_o,
  output logic [irbs_pkg::DELAY_W-1:0]   next_delay_us_o,
  output logic                           busy_res_o,
  output logic                           done_res_o
);
  import irbs_pkg::*;

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int IW    = $clog2(MAX_ENTRIES + 2);
  localparam int ACC_W = ENTRY_W + $clog2(MAX_ENTRIES) + 3;

  // configuration
  logic [SEQ_W-1:0] seq_len_q;
  logic [IVL_W-1:0] interval_q;
  logic [REP_W-1:0] min_rep_q;
  logic             cfg_we;

  // sequencer
  state_e             state_q, state_d;
  op_e                op_q;
  logic [IDX_W-1:0]   idx_q;
  logic [ENTRY_W-1:0] val_q;
  logic [IW-1:0]      pi_q, pi_d;
  logic [REP_W-1:0]   rep_q, rep_d;
  logic               playing_q, playing_d;
  logic               carrier_q, carrier_d;
  logic [IW-1:0]      k_q, k_d;
  logic               rvld_q, rvld_d;

  // table memory
  logic [ENTRY_W-1:0] tbl_mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [31:0]        idx_ext;
  logic               idx_ok;

  // result register
  logic               res_vld_q;
  logic               res_car_q, res_busy_q, res_done_q;
  logic [DELAY_W-1:0] res_dly_q;
  logic               commit;
  logic               r_car, r_busy, r_done;
  logic [DELAY_W-1:0] r_dly;
  logic               slot_free;

  // step datapath
  logic [IW-1:0]      len;
  logic               in_rng;
  logic               step_car;
  logic [ENTRY_W-1:0] step_dly;
  logic [IW-1:0]      step_pi;

  acc_ctrl_t          acc_ctrl;
  logic [DELAY_W-1:0] pause;

  // ---------------- APB ----------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q  <= '0;
      interval_q <= IVL_RESET;
      min_rep_q  <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_SEQ_LEN:  seq_len_q  <= pwdata[SEQ_W-1:0];
        REG_INTERVAL: interval_q <= pwdata[IVL_W-1:0];
        REG_MIN_REP:  min_rep_q  <= pwdata[REP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SEQ_LEN:  prdata = APB_DW'(seq_len_q);
      REG_INTERVAL: prdata = APB_DW'(interval_q);
      REG_MIN_REP:  prdata = APB_DW'(min_rep_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  assign len = (32'(seq_len_q) > MAX_ENTRIES) ? IW'(MAX_ENTRIES) : IW'(seq_len_q);

  assign idx_ext = 32'(idx_q);
  assign idx_ok  = idx_ext < MAX_ENTRIES;

  assign in_rng   = pi_q < len;
  assign step_car = in_rng ? ~pi_q[0] : carrier_q;
  assign step_dly = in_rng ? rdata_q : '0;
  assign step_pi  = in_rng ? pi_q + IW'(1) : pi_q;

  assign slot_free = !res_vld_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[idx_ext[AW-1:0]] <= val_q;
    end
    if (mem_re) begin
      rdata_q <= tbl_mem[mem_raddr];
    end
  end

  irbs_pause_acc #(
    .ACC_W (ACC_W)
  ) u_pause_acc (
    .clk_i      (clk_i),
    .ctrl_i     (acc_ctrl),
    .interval_i (interval_q),
    .word_i     (rdata_q),
    .rep_nz_i   (rep_q != '0),
    .pause_o    (pause)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d   = state_q;
    pi_d      = pi_q;
    rep_d     = rep_q;
    playing_d = playing_q;
    carrier_d = carrier_q;
    k_d       = k_q;
    rvld_d    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = pi_q[AW-1:0];
    acc_ctrl  = '0;
    commit    = 1'b0;
    r_car     = 1'b0;
    r_dly     = '0;
    r_busy    = 1'b0;
    r_done    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (op_q)
          OP_LOAD, OP_STOP: begin
            if (slot_free) begin
              playing_d = 1'b0;
              pi_d      = '0;
              rep_d     = '0;
              carrier_d = 1'b0;
              mem_we    = (op_q == OP_LOAD) && idx_ok;
              commit    = 1'b1;
              state_d   = ST_IDLE;
            end
          end
          OP_TX, OP_RPT: begin
            if (len != '0) begin
              playing_d = 1'b1;
              pi_d      = '0;
              rep_d     = (op_q == OP_TX) ? min_rep_q : '0;
              carrier_d = 1'b0;
              state_d   = ST_READ;
            end else if (slot_free) begin
              playing_d = 1'b0;
              pi_d      = '0;
              rep_d     = '0;
              carrier_d = 1'b0;
              commit    = 1'b1;
              state_d   = ST_IDLE;
            end
          end
          OP_ALARM: begin
            if (playing_q) begin
              state_d = ST_READ;
            end else if (slot_free) begin
              commit  = 1'b1;
              r_car   = carrier_q;
              r_busy  = playing_q;
              state_d = ST_IDLE;
            end
          end
          default: begin
            if (slot_free) begin
              commit  = 1'b1;
              r_car   = carrier_q;
              r_busy  = playing_q;
              state_d = ST_IDLE;
            end
          end
        endcase
      end

      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_STEP;
      end

      ST_STEP: begin
        if (step_dly != '0) begin
          if (slot_free) begin
            carrier_d = step_car;
            pi_d      = step_pi;
            commit    = 1'b1;
            r_car     = step_car;
            r_dly     = DELAY_W'(step_dly);
            r_busy    = playing_q;
            state_d   = ST_IDLE;
          end
        end else if (step_pi == len) begin
          // end of frame: sweep the table for the pause
          carrier_d     = 1'b0;
          pi_d          = step_pi + IW'(1);
          acc_ctrl.load = 1'b1;
          k_d           = '0;
          state_d       = ST_SUM;
        end else if (step_pi > len && rep_q != '0) begin
          if (slot_free) begin
            carrier_d = 1'b0;
            rep_d     = rep_q - REP_W'(1);
            pi_d      = '0;
            commit    = 1'b1;
            r_dly     = DELAY_W'(1);
            r_busy    = playing_q;
            state_d   = ST_IDLE;
          end
        end else begin
          // zero entry mid-frame or last repeat done
          if (slot_free) begin
            carrier_d = 1'b0;
            pi_d      = step_pi;
            playing_d = 1'b0;
            commit    = 1'b1;
            r_done    = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end

      ST_SUM: begin
        acc_ctrl.sub = rvld_q;
        if (k_q < len) begin
          mem_re    = 1'b1;
          mem_raddr = k_q[AW-1:0];
          k_d       = k_q + IW'(1);
          rvld_d    = 1'b1;
        end else if (!rvld_q) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (slot_free) begin
          commit  = 1'b1;
          r_car   = carrier_q;
          r_dly   = pause;
          r_busy  = playing_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pi_q      <= '0;
      rep_q     <= '0;
      playing_q <= 1'b0;
      carrier_q <= 1'b0;
      k_q       <= '0;
      rvld_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pi_q      <= pi_d;
      rep_q     <= rep_d;
      playing_q <= playing_d;
      carrier_q <= carrier_d;
      k_q       <= k_d;
      rvld_q    <= rvld_d;
      if (commit) begin
        res_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      op_q  <= op_e'(opcode_i);
      idx_q <= entry_index_i;
      val_q <= entry_value_i;
    end
    if (commit) begin
      res_car_q  <= r_car;
      res_dly_q  <= r_dly;
      res_busy_q <= r_busy;
      res_done_q <= r_done;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = res_vld_q;
  assign carrier_on_o    = res_car_q;
  assign next_delay_us_o = res_dly_q;
  assign busy_res_o      = res_busy_q;
  assign done_res_o      = res_done_q;

endmodule

// File: rtl/irbs_checker.sv
// ----------------------------------------------------------------------------
// irbs_checker
// Port-level checks of the IR burst sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "ir_burst_sequencer_unit_defines.svh"

module irbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        carrier_on_o,
  input logic [25:0] next_delay_us_o,
  input logic        busy_res_o,
  input logic        done_res_o
);

  // a done beat closes playback with the carrier off
  `IRBS_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, out_valid_o && done_res_o, !busy_res_o && !carrier_on_o, "done beat while busy or carrier on")

  // nothing is scheduled and no carrier once playback is over
  `IRBS_ASSERT_IMPL(a_idle_quiet, clk_i, rst_ni, out_valid_o && !busy_res_o, !carrier_on_o && next_delay_us_o == 26'd0, "idle result with carrier or delay")

  // one beat at a time: the block stalls right after taking a beat
  `IRBS_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken back to back")

  `IRBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(next_delay_us_o) && $stable(done_res_o), "stalled output beat changed")

endmodule

bind ir_burst_sequencer_unit irbs_checker u_irbs_checker (.*);

// File: tb/sv/tb_ir_burst_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_ir_burst_sequencer_unit
// Self-checking bench for the IR burst sequencer: a directed table of beats
// and register writes, then random phases of playback traffic. Every result
// beat is checked field by field against an in-bench model or a typed-in result.
// ----------------------------------------------------------------------------
module tb_ir_burst_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import irbs_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int N_PHASES    = 12;
  localparam int PHASE_BEATS = 150;
  localparam int DRAIN_CYCLES = 160;

  // opcodes the block does not decode
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic               carrier;
    logic [DELAY_W-1:0] delay;
    logic               busy;
    logic               done;
  } burst_event_t;

  typedef enum logic [1:0] {
    ROW_BEAT,   // beat checked against the model
    ROW_CHECK,  // beat with a typed-in result
    ROW_REG     // register write while idle
  } row_kind_e;

  typedef struct {
    row_kind_e    kind;
    logic [2:0]   op;
    logic [6:0]   idx;
    logic [31:0]  val;
    burst_event_t res;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     opcode_i = '0;
  logic [IDX_W-1:0]    entry_index_i = '0;
  logic [ENTRY_W-1:0]  entry_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                carrier_on_o;
  logic [DELAY_W-1:0]  next_delay_us_o;
  logic                busy_res_o;
  logic                done_res_o;

  ir_burst_sequencer_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .opcode_i(opcode_i), .entry_index_i(entry_index_i), .entry_value_i(entry_value_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .carrier_on_o(carrier_on_o), .next_delay_us_o(next_delay_us_o),
    .busy_res_o(busy_res_o), .done_res_o(done_res_o)
  );

  // sequencer model state
  logic [ENTRY_W-1:0]  dur_tbl [TABLE_DEPTH];
  logic                dur_written [TABLE_DEPTH];
  logic [8:0]          play_pos;
  logic [REP_W-1:0]    reps_left;
  logic                playing_q;
  logic                carrier_q;
  logic [SEQ_W-1:0]    seq_len_q = '0;
  logic [IVL_W-1:0]    interval_q = IVL_RESET;
  logic [REP_W-1:0]    min_rep_q = '0;

  burst_event_t        burst_event_q [$];
  int unsigned         fail_count = 0;
  int unsigned         shown_count = 0;
  int unsigned         tx_mode = 1;
  int unsigned         rx_mode = 1;
  int unsigned         stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [8:0] active_len();
    return (seq_len_q > TABLE_DEPTH) ? 9'(TABLE_DEPTH) : {1'b0, seq_len_q};
  endfunction

  // first entry inside the active length that was never loaded
  function automatic logic [8:0] first_hole();
    logic [8:0] k;
    k = '0;
    while (k < active_len() && dur_written[k[6:0]]) k++;
    return k;
  endfunction

  function automatic int unsigned pick_gap(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ENTRY_W-1:0] pick_dur();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return ENTRY_W'($urandom());
      default: return ENTRY_W'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic stim_row_t mk_row(row_kind_e k, logic [2:0] op, logic [6:0] idx,
                                       logic [31:0] val, logic c, logic [DELAY_W-1:0] d,
                                       logic b, logic dn);
    stim_row_t row;
    row.kind = k;
    row.op = op;
    row.idx = idx;
    row.val = val;
    row.res.carrier = c;
    row.res.delay = d;
    row.res.busy = b;
    row.res.done = dn;
    return row;
  endfunction

  task automatic stop_play();
    playing_q = 1'b0;
    play_pos = '0;
    reps_left = '0;
    carrier_q = 1'b0;
  endtask

  // one playback step: next mark/space, frame pause, repeat or finish
  task automatic play_next(output logic [DELAY_W-1:0] dly, output logic fin);
    logic [8:0] len;
    longint     pause;
    len = active_len();
    dly = '0;
    fin = 1'b0;
    if (play_pos < len) begin
      carrier_q = ~play_pos[0];
      dly = DELAY_W'(dur_tbl[play_pos[6:0]]);
      play_pos++;
    end
    if (dly == '0) begin
      carrier_q = 1'b0;
      if (play_pos == len) begin
        play_pos++;
        pause = longint'(interval_q) * longint'(US_PER_MS);
        for (int k = 0; k < len; k++) pause -= longint'(dur_tbl[k]);
        if (reps_left != 0) pause -= 1;
        if (pause < 1) pause = 1;
        dly = DELAY_W'(pause);
      end else if (play_pos > len && reps_left != 0) begin
        reps_left--;
        play_pos = '0;
        dly = DELAY_W'(1);
      end else begin
        playing_q = 1'b0;
        fin = 1'b1;
      end
    end
  endtask

  task automatic burst_step(input logic [2:0] op, input logic [6:0] idx,
                            input logic [ENTRY_W-1:0] val, output burst_event_t ev);
    logic [DELAY_W-1:0] dly;
    logic               fin;
    dly = '0;
    fin = 1'b0;
    case (op)
      OP_LOAD: begin
        stop_play();
        dur_tbl[idx] = val;
        dur_written[idx] = 1'b1;
      end
      OP_TX, OP_RPT: begin
        stop_play();
        if (active_len() != 0) begin
          reps_left = (op == OP_TX) ? min_rep_q : '0;
          playing_q = 1'b1;
          play_next(dly, fin);
        end
      end
      OP_STOP: stop_play();
      OP_ALARM: begin
        if (playing_q) play_next(dly, fin);
      end
      default: ;
    endcase
    ev.carrier = carrier_q;
    ev.delay = dly;
    ev.busy = playing_q;
    ev.done = fin;
  endtask

  task automatic send_beat(input logic [2:0] op, input logic [6:0] idx,
                           input logic [ENTRY_W-1:0] val, input logic typed,
                           input burst_event_t typed_res);
    int unsigned  gap;
    burst_event_t ev;
    gap = pick_gap(tx_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    entry_index_i <= idx;
    entry_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    burst_step(op, idx, val, ev);
    burst_event_q.push_back(typed ? typed_res : ev);
  endtask

  // drop valid and hold off until every expected beat has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (burst_event_q.size() != 0);
  endtask

  task automatic reg_write(input logic [1:0] widx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {widx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (widx)
      REG_SEQ_LEN:  seq_len_q = data[SEQ_W-1:0];
      REG_INTERVAL: interval_q = data[IVL_W-1:0];
      REG_MIN_REP:  min_rep_q = data[REP_W-1:0];
      default: ;
    endcase
  endtask

  // result side: random stall, compare each accepted beat with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (burst_event_q.size() == 0) begin
          fail_count++;
          if (shown_count < 10) begin
            shown_count++;
            $display("unexpected result beat: carrier %0b delay %0d busy %0b done %0b",
                     carrier_on_o, next_delay_us_o, busy_res_o, done_res_o);
          end
        end else begin
          if (carrier_on_o !== burst_event_q[0].carrier ||
              next_delay_us_o !== burst_event_q[0].delay ||
              busy_res_o !== burst_event_q[0].busy ||
              done_res_o !== burst_event_q[0].done) begin
            fail_count++;
            if (shown_count < 10) begin
              shown_count++;
              $display("mismatch: exp carrier %0b delay %0d busy %0b done %0b, got %0b %0d %0b %0b",
                       burst_event_q[0].carrier, burst_event_q[0].delay,
                       burst_event_q[0].busy, burst_event_q[0].done,
                       carrier_on_o, next_delay_us_o, busy_res_o, done_res_o);
            end
          end
          void'(burst_event_q.pop_front());
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (rx_mode != 0 && $urandom_range(0, 9) < 3) begin
        out_stall_i <= 1'b1;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    stim_row_t    rows [$];
    burst_event_t none;
    logic [2:0]   op;
    logic [6:0]   idx;
    logic [ENTRY_W-1:0] val;
    logic [8:0]   hole;
    int unsigned  r;

    none = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      dur_tbl[k] = '0;
      dur_written[k] = 1'b0;
    end
    stop_play();

    // reset defaults: empty sequence, 108 ms interval, no repeats
    rows.push_back(mk_row(ROW_CHECK, OP_ALARM, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_TX, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_RPT, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_UNDEF_HI, 7'h7f, 32'hffffff, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_STOP, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_LOAD, 7'h00, 32'hffffff, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_LOAD, 7'h01, 1, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_LOAD, 7'h7f, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_REG, OP_STOP, REG_SEQ_LEN, 2, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_TX, 7'h00, 0, 1, 26'hffffff, 1, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_ALARM, 7'h00, 0, 0, 1, 1, 0));
    // entries exceed the interval: pause floors at one
    rows.push_back(mk_row(ROW_CHECK, OP_ALARM, 7'h00, 0, 0, 1, 1, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_ALARM, 7'h00, 0, 0, 0, 0, 1));
    rows.push_back(mk_row(ROW_REG, OP_STOP, REG_MIN_REP, 255, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_REG, OP_STOP, REG_INTERVAL, 65535, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_BEAT, OP_TX, 7'h55, 32'h2aaaaa, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_BEAT, OP_UNDEF_LO, 7'h2a, 32'h555555, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_BEAT, OP_ALARM, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_BEAT, OP_ALARM, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_BEAT, OP_ALARM, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_BEAT, OP_RPT, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_STOP, 7'h00, 0, 0, 0, 0, 0));
    // zero entry in mid-sequence ends playback at once
    rows.push_back(mk_row(ROW_BEAT, OP_LOAD, 7'h01, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_BEAT, OP_LOAD, 7'h02, 5, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_REG, OP_STOP, REG_SEQ_LEN, 3, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_BEAT, OP_TX, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_BEAT, OP_ALARM, 7'h00, 0, 0, 0, 0, 0));
    // zero first entry: the start itself finishes
    rows.push_back(mk_row(ROW_BEAT, OP_LOAD, 7'h00, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(ROW_CHECK, OP_TX, 7'h00, 0, 0, 0, 0, 1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        wait_idle();
        reg_write(rows[i].idx[1:0], rows[i].val);
      end else begin
        send_beat(rows[i].op, rows[i].idx, rows[i].val[ENTRY_W-1:0],
                  rows[i].kind == ROW_CHECK, rows[i].res);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      // a longer sequence must not play on into entries never loaded
      if (playing_q) begin
        send_beat(OP_STOP, '0, '0, 1'b0, none);
        wait_idle();
      end
      r = $urandom_range(0, 15);
      reg_write(REG_SEQ_LEN, (r == 0) ? 0 : (r == 1) ? TABLE_DEPTH : (r == 2) ? 255 :
                             (r == 3) ? $urandom_range(129, 255) : $urandom_range(1, 8));
      r = $urandom_range(0, 9);
      reg_write(REG_INTERVAL, (r == 0) ? 0 : (r == 1) ? 65535 :
                              (r == 2) ? $urandom_range(0, 65535) : $urandom_range(1, 20));
      r = $urandom_range(0, 9);
      reg_write(REG_MIN_REP, (r == 0) ? 255 : (r == 1) ? $urandom_range(0, 255) :
                             $urandom_range(0, 3));
      tx_mode = (ph % 4 == 0) ? 0 : 1;
      rx_mode = (ph % 3 == 1) ? 0 : 1;

      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 99) < 2) wait_idle();
        r = $urandom_range(0, 99);
        if (!playing_q) begin
          op = (r < 25) ? OP_LOAD : (r < 45) ? OP_TX : (r < 65) ? OP_RPT :
               (r < 78) ? OP_ALARM : (r < 88) ? OP_STOP :
               3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        end else begin
          op = (r < 85) ? OP_ALARM : (r < 89) ? OP_LOAD : (r < 92) ? OP_STOP :
               (r < 94) ? OP_TX : (r < 96) ? OP_RPT :
               3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        end
        idx = 7'($urandom_range(0, TABLE_DEPTH - 1));
        val = pick_dur();
        if (op == OP_LOAD && active_len() != 0 && $urandom_range(0, 1) == 1)
          idx = 7'($urandom_range(0, active_len() - 1));
        // never play a table with holes: fill the first hole instead
        if (op == OP_TX || op == OP_RPT) begin
          hole = first_hole();
          if (hole < active_len()) begin
            op = OP_LOAD;
            idx = hole[6:0];
          end
        end
        send_beat(op, idx, val, 1'b0, none);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (burst_event_q.size() != 0) begin
      fail_count++;
      $display("%0d result beats never arrived", burst_event_q.size());
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: ir_burst_sequencer_unit.f
+incdir+rtl
rtl/irbs_pkg.sv
rtl/irbs_pause_acc.sv
rtl/ir_burst_sequencer_unit.sv
rtl/irbs_checker.sv
tb/sv/tb_ir_burst_sequencer_unit.sv
